// File: src/acs_pkg.sv
// shared types, codes and constants of the alignment coverage segmenter
// used by the controller, datapath and top level; depends on nothing else
`default_nettype none

package acs_pkg;

   localparam int POSITIONS_DEFAULT = 4096;

   localparam int USED_W = 13;
   localparam logic [USED_W-1:0] USED_RESET = 13'd4096;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LEN_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

   // one table entry: longest alignment covering a position
   typedef struct packed {
      logic        valid;
      logic [15:0] partner;
      logic [19:0] pcoord;
      logic [12:0] len;
      logic        is_unique;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [12:0]     first_pos;
      logic [12:0]     end_pos;
      logic [15:0]     partner_index;
      logic [19:0]     partner_first;
      logic [19:0]     partner_end;
      logic [12:0]     align_len;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                seg_valid;
      logic [12:0]         seg_first;
      logic [12:0]         seg_last;
      logic [15:0]         seg_partner;
      logic [20:0]         seg_partner_first;
      logic [20:0]         seg_partner_last;
      logic [13:0]         seg_span;
      logic                seg_unique;
      logic                scan_done;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic sweep_wr;
      logic rec_rd;
      logic rec_wr;
      logic scan_rd;
      logic scan_close;
      logic scan_last;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rec_walk;
      logic            sweep_last;
      logic            rec_last;
      logic            scan_is_last;
      logic            out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: src/acs_ram.sv
// generic single write port, single read port ram with registered read
// standalone, no package needed
`default_nettype none

module acs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/acs_dp.sv
// datapath: item register, position table ram, walk counters, scan run state,
// shared segment report unit and output register; uses acs_pkg and acs_ram
`default_nettype none

module acs_dp #(
   parameter int POSITIONS = acs_pkg::POSITIONS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire acs_pkg::cmd_type          cmd,
   output acs_pkg::sts_type               sts,
   input  wire acs_pkg::item_type         req_item,
   input  wire logic [acs_pkg::USED_W-1:0] used_positions,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output acs_pkg::result_type            rsp_result
);

   import acs_pkg::*;

   localparam int AW = $clog2(POSITIONS);
   localparam int EW = (AW + 1 > USED_W) ? AW + 1 : USED_W;
   localparam int CW = (EW + 1 > 14) ? EW + 1 : 14;
   localparam int DW = (CW > 22) ? CW : 22;
   localparam logic signed [CW-1:0] ONE_C = 1;

   item_type   item_ff;
   logic [AW-1:0] ctr_ff, ctr_in;
   logic [19:0]   pc_ff, pc_in;
   logic [12:0]   rem_ff, rem_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] rs_pos_ff, rs_pos_in;
   entry_type  rs_ff, rs_in;
   entry_type  prev_ff, prev_in;
   result_type res_ff, res_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   // ram ports
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_entry;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type       cur;

   acs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POSITIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur = entry_type'(rd_data);

   // effective table length, clamped to 1..POSITIONS
   logic [EW-1:0] eff_used;
   always_comb begin
      if (used_positions == '0) begin
         eff_used = EW'(1);
      end else if (EW'(used_positions) > EW'(POSITIONS)) begin
         eff_used = EW'(POSITIONS);
      end else begin
         eff_used = EW'(used_positions);
      end
   end

   // record checks
   logic [13:0]   sum14;
   logic [CW-1:0] first_m1;
   logic          len_bad, range_bad, len_zero;
   logic [STATUS_W-1:0] check_code;
   always_comb begin
      sum14 = {1'b0, item_ff.first_pos} + {1'b0, item_ff.align_len};
      first_m1 = CW'(item_ff.first_pos) - CW'(1);
      len_bad = (sum14 != {1'b0, item_ff.end_pos}) ||
                (({1'b0, item_ff.partner_first} + 21'(item_ff.align_len)) !=
                 {1'b0, item_ff.partner_end});
      len_zero = (item_ff.align_len == '0);
      range_bad = (item_ff.first_pos == '0) ||
                  (CW'(sum14) > (CW'(eff_used) + CW'(1)));
      if (len_bad) begin
         check_code = STATUS_LEN_MISMATCH;
      end else if (!len_zero && range_bad) begin
         check_code = STATUS_OUT_OF_RANGE;
      end else begin
         check_code = STATUS_OK;
      end
   end

   // read-modify-write of one position during a record walk
   entry_type new_entry;
   logic      keep_old, same_len;
   always_comb begin
      new_entry.valid     = 1'b1;
      new_entry.partner   = item_ff.partner_index;
      new_entry.pcoord    = pc_ff;
      new_entry.len       = item_ff.align_len;
      new_entry.is_unique = 1'b1;
      keep_old = cur.valid && (cur.len >= item_ff.align_len);
      same_len = (cur.len == item_ff.align_len);
   end

   always_comb begin
      rd_en   = cmd.rec_rd || cmd.scan_rd;
      rd_addr = cmd.scan_rd ? cursor_ff : ctr_ff;
      wr_addr = ctr_ff;
      wr_en   = 1'b0;
      wr_entry = '0;
      if (cmd.sweep_wr) begin
         wr_en = 1'b1;
      end else if (cmd.rec_wr) begin
         wr_en = !keep_old || same_len;
         if (keep_old) begin
            wr_entry = cur;
            wr_entry.is_unique = 1'b0;
         end else begin
            wr_entry = new_entry;
         end
      end
   end

   // scan neighbor test
   logic is_last, nb;
   always_comb begin
      is_last = (CW'(cursor_ff) + CW'(1)) >= CW'(eff_used);
      nb = cur.valid && prev_ff.valid && (cur.partner == prev_ff.partner) &&
           (cur.is_unique == prev_ff.is_unique) &&
           (({1'b0, cur.pcoord} == ({1'b0, prev_ff.pcoord} + 21'd1)) ||
            ({1'b0, prev_ff.pcoord} == ({1'b0, cur.pcoord} + 21'd1)));
   end

   // shared segment report unit: run start vs previous entry
   logic signed [CW-1:0] cs_s, pos_s, ce_s, dist_s, sf_s, sl_s;
   logic signed [20:0]   pd_s, apd_s, span_s;
   logic                 rep_ok;
   always_comb begin
      cs_s  = $signed(CW'(rs_pos_ff));
      pos_s = $signed(CW'(cursor_ff));
      ce_s  = cmd.scan_last ? pos_s : (pos_s - ONE_C);
      dist_s = ce_s - cs_s;
      pd_s = $signed({1'b0, prev_ff.pcoord}) - $signed({1'b0, rs_ff.pcoord});
      apd_s = (pd_s < 21'sd0) ? -pd_s : pd_s;
      span_s = pd_s + 21'sd1;
      sf_s = cs_s + ONE_C;
      sl_s = ce_s + ONE_C;
      rep_ok = rs_ff.valid && prev_ff.valid && (rs_ff.partner == prev_ff.partner) &&
               (dist_s > ONE_C) && (DW'(dist_s) == DW'(apd_s));
   end

   always_comb begin
      ctr_in    = ctr_ff;
      pc_in     = pc_ff;
      rem_in    = rem_ff;
      cursor_in = cursor_ff;
      rs_in     = rs_ff;
      rs_pos_in = rs_pos_ff;
      prev_in   = prev_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      out_valid_in = out_valid_ff;

      if (cmd.capture) begin
         res_in = '0;
      end

      if (cmd.decode) begin
         ctr_in = (item_ff.op == OP_CLEAR) ? '0 : first_m1[AW-1:0];
         pc_in  = item_ff.partner_first;
         rem_in = item_ff.align_len;
         res_in.status = (item_ff.op == OP_RECORD) ? check_code : STATUS_OK;
      end

      if (cmd.sweep_wr || cmd.rec_wr) begin
         ctr_in = ctr_ff + 1'b1;
      end
      if (cmd.rec_wr) begin
         pc_in  = pc_ff + 20'd1;
         rem_in = rem_ff - 13'd1;
      end

      if (cmd.scan_close) begin
         if (!nb && rs_ff.valid && rep_ok) begin
            res_in.seg_valid         = 1'b1;
            res_in.seg_first         = sf_s[12:0];
            res_in.seg_last          = sl_s[12:0];
            res_in.seg_partner       = rs_ff.partner;
            res_in.seg_partner_first = {1'b0, rs_ff.pcoord};
            res_in.seg_partner_last  = {1'b0, prev_ff.pcoord};
            res_in.seg_span          = span_s[13:0];
            res_in.seg_unique        = prev_ff.is_unique;
         end
         // run bookkeeping
         if (!(nb && rs_ff.valid) && cur.valid) begin
            rs_in     = cur;
            rs_pos_in = cursor_ff;
         end else if (!nb) begin
            rs_in     = '0;
            rs_pos_in = '0;
         end
         prev_in = cur;
         if (!is_last) begin
            cursor_in = cursor_ff + 1'b1;
         end
      end

      if (cmd.scan_last) begin
         // previous entry now holds the entry at the cursor
         if (!res_ff.seg_valid && rep_ok) begin
            res_in.seg_valid         = 1'b1;
            res_in.seg_first         = sf_s[12:0];
            res_in.seg_last          = sl_s[12:0];
            res_in.seg_partner       = rs_ff.partner;
            res_in.seg_partner_first = {1'b0, rs_ff.pcoord};
            res_in.seg_partner_last  = {1'b0, prev_ff.pcoord};
            res_in.seg_span          = span_s[13:0];
            res_in.seg_unique        = prev_ff.is_unique;
         end
         res_in.scan_done = 1'b1;
      end

      if (cmd.scan_last || (cmd.decode && (item_ff.op == OP_CLEAR))) begin
         cursor_in = '0;
         rs_in     = '0;
         rs_pos_in = '0;
         prev_in   = '0;
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_in       = res_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      pc_ff  <= pc_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      out_ff <= out_in;
      if (reset) begin
         ctr_ff       <= '0;
         cursor_ff    <= '0;
         rs_ff        <= '0;
         rs_pos_ff    <= '0;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ctr_ff       <= ctr_in;
         cursor_ff    <= cursor_in;
         rs_ff        <= rs_in;
         rs_pos_ff    <= rs_pos_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      sts.op           = item_ff.op;
      sts.rec_walk     = !len_bad && !len_zero && !range_bad;
      sts.sweep_last   = (ctr_ff == AW'(POSITIONS - 1));
      sts.rec_last     = (rem_ff == 13'd1);
      sts.scan_is_last = is_last;
      sts.out_free     = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

`default_nettype wire

// File: src/acs_ctrl.sv
// controller state machine: sequences clearing sweeps, record walks and scan
// steps and hands results to the output register; uses acs_pkg
`default_nettype none

module acs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output acs_pkg::cmd_type      cmd,
   input  wire acs_pkg::sts_type sts
);

   import acs_pkg::*;

   localparam logic [3:0] S_INIT       = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_DECODE     = 4'd2;
   localparam logic [3:0] S_CLEAR      = 4'd3;
   localparam logic [3:0] S_REC_RD     = 4'd4;
   localparam logic [3:0] S_REC_WR     = 4'd5;
   localparam logic [3:0] S_SCAN_RD    = 4'd6;
   localparam logic [3:0] S_SCAN_CLOSE = 4'd7;
   localparam logic [3:0] S_SCAN_LAST  = 4'd8;
   localparam logic [3:0] S_FINISH     = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (sts.op)
               OP_CLEAR:  state_in = S_CLEAR;
               OP_RECORD: state_in = sts.rec_walk ? S_REC_RD : S_FINISH;
               OP_SCAN:   state_in = S_SCAN_RD;
               default:   state_in = S_FINISH;
            endcase
         end
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_REC_RD: begin
            cmd.rec_rd = 1'b1;
            state_in = S_REC_WR;
         end
         S_REC_WR: begin
            cmd.rec_wr = 1'b1;
            state_in = sts.rec_last ? S_FINISH : S_REC_RD;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCAN_CLOSE;
         end
         S_SCAN_CLOSE: begin
            cmd.scan_close = 1'b1;
            state_in = sts.scan_is_last ? S_SCAN_LAST : S_FINISH;
         end
         S_SCAN_LAST: begin
            cmd.scan_last = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/alignment_coverage_segmenter_unit.sv
// alignment coverage segmenter, top level: stream ports, csr port, controller and datapath
// sequencing per item: unused opcodes and failed or zero-length records go straight to the
//   output register, a scan step reads one table entry, a record walk takes one table read
//   step and one write step per covered position, and a clear sweeps every table position
// one item at a time: the next transfer is taken once the previous result sits in the output register
// reset: synchronous, then a clearing pass over the table with req_tready low
`default_nettype none

module alignment_coverage_segmenter_unit #(
   parameter int POSITIONS = acs_pkg::POSITIONS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_pos[12:0] end_pos[25:13] partner_index[41:26] partner_first[61:42]
   // partner_end[81:62] align_len[94:82] zero[95]
   input  wire logic [95:0]  req_tdata,
   // op[1:0]
   input  wire logic [1:0]   req_tuser,
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // seg_first[12:0] seg_last[25:13] seg_partner[41:26] seg_partner_first[62:42]
   // seg_partner_last[83:63] seg_span[97:84] seg_unique[98] zero[103:99]
   output logic [103:0]      rsp_tdata,
   // status[1:0] seg_valid[2]
   output logic [2:0]        rsp_tuser,
   // scan_done
   output logic              rsp_tlast,
   // csr port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   import acs_pkg::*;

   // used_positions register at byte address 0
   logic [USED_W-1:0] used_ff, used_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      used_in = used_ff;
      if (csr_wr && (csr_paddr[2] == 1'b0)) begin
         used_in = csr_pwdata[USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= USED_RESET;
      end else begin
         used_ff <= used_in;
      end
   end

   // reads return the register, nothing beyond it
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {{(32 - USED_W){1'b0}}, used_ff} : '0;

   // unpack request transfer
   item_type req_item;
   always_comb begin
      req_item.op            = req_tuser;
      req_item.first_pos     = req_tdata[12:0];
      req_item.end_pos       = req_tdata[25:13];
      req_item.partner_index = req_tdata[41:26];
      req_item.partner_first = req_tdata[61:42];
      req_item.partner_end   = req_tdata[81:62];
      req_item.align_len     = req_tdata[94:82];
   end

   cmd_type    cmd;
   sts_type    sts;
   result_type rsp_result;

   acs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   acs_dp #(
      .POSITIONS (POSITIONS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_item       (req_item),
      .used_positions (used_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_result     (rsp_result)
   );

   // pack response transfer
   assign rsp_tdata = {5'b0,
                       rsp_result.seg_unique,
                       rsp_result.seg_span,
                       rsp_result.seg_partner_last,
                       rsp_result.seg_partner_first,
                       rsp_result.seg_partner,
                       rsp_result.seg_last,
                       rsp_result.seg_first};
   assign rsp_tuser = {rsp_result.seg_valid, rsp_result.status};
   assign rsp_tlast = rsp_result.scan_done;

endmodule

`default_nettype wire

// File: src/acs_checker.sv
// port-level checks of the response stream, bound to the top level
// needs only the top-level ports
`default_nettype none

module acs_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic [2:0]   rsp_tuser,
   input wire logic         rsp_tlast
);

   // stalled transfer stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transfer dropped while stalled");

   // stalled payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // no segment means all segment fields are zero
   a_seg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata == '0)
      else $error("segment fields set without a segment");

   // an error status never carries a segment or a scan end
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != 2'd0) |-> !rsp_tuser[2] && !rsp_tlast)
      else $error("error status with segment or scan end");

endmodule

bind alignment_coverage_segmenter_unit acs_checker u_acs_checker (.*);

`default_nettype wire
